// ===== src/gwm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the grid wall map with pillar check.
// No dependencies; the interfaces, the pillar evaluator and the top level refer to it by scoped names.
package gwm_pkg;

    localparam int REQ_W   = 3;
    localparam int COORD_W = 8;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    // Wide enough for a row count of up to 1024 and for a signed row coordinate.
    localparam int LIM_W   = 11;
    localparam int ROW_W   = 12;
    localparam int CNT_W   = 4;
    localparam int PILLAR_LIMIT = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET_WALL     = 3'd0,
        REQ_SET_FLOOR    = 3'd1,
        REQ_QUERY_WALL   = 3'd2,
        REQ_QUERY_PILLAR = 3'd3,
        REQ_SCAN         = 3'd4
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 2'd0,
        CFG_COLS_IN_USE = 2'd1
    } t_cfg_idx;

    // Which of the three window rows lie inside the active area.
    typedef struct packed {
        logic top_ok;
        logic mid_ok;
        logic bot_ok;
    } t_win_flags;

endpackage

// ===== src/gwm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on gwm_pkg for the field widths.
interface gwm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [gwm_pkg::REQ_W-1:0]            req_type;
    logic signed [gwm_pkg::COORD_W-1:0]   x_pos;
    logic signed [gwm_pkg::COORD_W-1:0]   y_pos;

    modport source (output valid, output req_type, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input req_type, input x_pos, input y_pos, output ready);
endinterface

interface gwm_rsp_if;
    logic valid;
    logic ready;
    logic answer;
    logic write_rejected;

    modport source (output valid, output answer, output write_rejected, input ready);
    modport sink   (input valid, input answer, input write_rejected, output ready);
endinterface

// ===== src/gwm_row_mem.sv =====
`timescale 1ns / 1ps
// Row memory of the wall map: one row of cells per word, one write and one read port.
// Read data is registered, so it appears in the cycle after the read request.
module gwm_row_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(ROWS)-1:0]  i_waddr,
    input  logic [COLS-1:0]          i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(ROWS)-1:0]  i_raddr,
    output logic [COLS-1:0]          o_rdata
);

    logic [COLS-1:0] r_mem [ROWS];
    logic [COLS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gwm_pillar_eval.sv =====
`timescale 1ns / 1ps
// Pillar test for every column of the middle row of a three-row window.
// Depends on gwm_pkg; cells outside the active area are treated as walls.
module gwm_pillar_eval #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0]       i_top,
    input  logic [COLS-1:0]       i_mid,
    input  logic [COLS-1:0]       i_bot,
    input  gwm_pkg::t_win_flags   i_flags,
    input  logic [COLS-1:0]       i_col_act,
    output logic [COLS-1:0]       o_pillar
);

    localparam int CW = gwm_pkg::CNT_W;

    // Each row is widened by one wall column on either side.
    logic [COLS+1:0] e_top;
    logic [COLS+1:0] e_mid;
    logic [COLS+1:0] e_bot;

    assign e_top = i_flags.top_ok ? {1'b1, i_top | ~i_col_act, 1'b1} : '1;
    assign e_mid = i_flags.mid_ok ? {1'b1, i_mid | ~i_col_act, 1'b1} : '1;
    assign e_bot = i_flags.bot_ok ? {1'b1, i_bot | ~i_col_act, 1'b1} : '1;

    for (genvar c = 0; c < COLS; c++) begin : g_col
        logic [CW-1:0] nbr_cnt;
        assign nbr_cnt = CW'(e_top[c]) + CW'(e_top[c+1]) + CW'(e_top[c+2])
                       + CW'(e_mid[c]) + CW'(e_mid[c+2])
                       + CW'(e_bot[c]) + CW'(e_bot[c+1]) + CW'(e_bot[c+2]);
        assign o_pillar[c] = e_mid[c+1] && (nbr_cnt < CW'(gwm_pkg::PILLAR_LIMIT));
    end

endmodule

// ===== src/grid_wall_map_pillar_check_top.sv =====
`timescale 1ns / 1ps
// Point requests (set, query wall, query pillar) read rows y-1, y and y+1 from the row
// memory, drain the window and answer from the done state; the next request is taken back in idle.
// A scan streams rows 0 through the active row count (one past the last active row) through
// the same window. Unknown request types go straight to the done state and read no rows.
// After reset the memory is cleared one row per cycle with no request taken; configuration
// writes are taken at all times. Registers reset to 64 by 64.
module grid_wall_map_pillar_check_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gwm_req_if.sink                           i_req,
    gwm_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gwm_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int XW  = $clog2(MAX_COLS);
    localparam int LW  = gwm_pkg::LIM_W;
    localparam int RW  = gwm_pkg::ROW_W;
    localparam int CDW = gwm_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_DRAIN0, S_DRAIN1, S_DONE
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_clr_addr;
    logic [gwm_pkg::CFG_W-1:0]   r_rows_in_use;
    logic [gwm_pkg::CFG_W-1:0]   r_cols_in_use;
    logic [gwm_pkg::REQ_W-1:0]   r_req;
    logic signed [RW-1:0]        r_x;
    logic signed [RW-1:0]        r_y;
    logic signed [RW-1:0]        r_row;
    logic signed [RW-1:0]        r_end;
    logic                        r_found;
    logic                        r_out_valid;
    logic                        r_answer;
    logic                        r_rej;

    logic                        r_rd_vld;
    logic                        r_rd_ok;
    logic                        r_win_new;
    gwm_pkg::t_win_flags         r_flags;
    logic [MAX_COLS-1:0]         r_top;
    logic [MAX_COLS-1:0]         r_mid;
    logic [MAX_COLS-1:0]         r_bot;

    logic [LW-1:0]               lim_rows;
    logic [LW-1:0]               lim_cols;
    logic [MAX_COLS-1:0]         col_act;
    logic [MAX_COLS-1:0]         pvec;
    logic [MAX_COLS-1:0]         rdata;
    logic [MAX_COLS-1:0]         bit_mask;
    logic [MAX_COLS-1:0]         wdata;
    logic [AW-1:0]               waddr;
    logic                        mem_we;
    logic                        mem_re;
    logic                        issue_ok;
    logic                        pt_in;
    logic                        is_set;
    logic                        in_fire;
    logic                        done_fire;
    logic                        scan_hit;
    logic [XW-1:0]               x_idx;
    logic signed [RW-1:0]        x_ext;
    logic signed [RW-1:0]        y_ext;
    logic                        n_answer;
    logic                        n_rej;

    // Effective area: the registers saturate at the grid size.
    assign lim_rows = (LW'(r_rows_in_use) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(r_rows_in_use);
    assign lim_cols = (LW'(r_cols_in_use) > LW'(MAX_COLS)) ? LW'(MAX_COLS) : LW'(r_cols_in_use);

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col_act
        assign col_act[c] = LW'(c) < lim_cols;
    end

    assign issue_ok = !r_row[RW-1] && (r_row[LW-1:0] < lim_rows);
    assign pt_in    = !r_x[RW-1] && (r_x[LW-1:0] < lim_cols)
                   && !r_y[RW-1] && (r_y[LW-1:0] < lim_rows);
    assign x_idx    = XW'(r_x[LW-1:0]);
    assign is_set   = (r_req == gwm_pkg::REQ_SET_WALL) || (r_req == gwm_pkg::REQ_SET_FLOOR);

    assign x_ext = {{(RW-CDW){i_req.x_pos[CDW-1]}}, i_req.x_pos};
    assign y_ext = {{(RW-CDW){i_req.y_pos[CDW-1]}}, i_req.y_pos};

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign done_fire   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.answer         = r_answer;
    assign o_rsp.write_rejected = r_rej;

    // Memory ports: the clearing pass and the write-back of a set share the write port.
    assign bit_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << x_idx;
    assign mem_re   = (r_state == S_READ) && issue_ok;
    assign mem_we   = (r_state == S_CLEAR) || (done_fire && is_set && pt_in);
    assign waddr    = (r_state == S_CLEAR) ? r_clr_addr : AW'(r_y[LW-1:0]);
    always_comb begin
        if (r_state == S_CLEAR) begin
            wdata = '0;
        end else if (r_req == gwm_pkg::REQ_SET_WALL) begin
            wdata = r_mid | bit_mask;
        end else begin
            wdata = r_mid & ~bit_mask;
        end
    end

    gwm_row_mem #(
        .ROWS (MAX_ROWS),
        .COLS (MAX_COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (mem_re),
        .i_raddr (AW'(r_row[LW-1:0])),
        .o_rdata (rdata)
    );

    gwm_pillar_eval #(
        .COLS (MAX_COLS)
    ) u_eval (
        .i_top     (r_top),
        .i_mid     (r_mid),
        .i_bot     (r_bot),
        .i_flags   (r_flags),
        .i_col_act (col_act),
        .o_pillar  (pvec)
    );

    assign scan_hit = r_win_new && r_flags.mid_ok && (|pvec);

    always_comb begin
        n_answer = 1'b0;
        n_rej    = 1'b0;
        unique case (r_req)
            gwm_pkg::REQ_SET_WALL,
            gwm_pkg::REQ_SET_FLOOR:    n_rej    = !pt_in;
            gwm_pkg::REQ_QUERY_WALL:   n_answer = pt_in ? r_mid[x_idx] : 1'b1;
            // A cell outside the area always has at least five wall neighbors.
            gwm_pkg::REQ_QUERY_PILLAR: n_answer = pt_in && pvec[x_idx];
            gwm_pkg::REQ_SCAN:         n_answer = r_found;
            default: ;
        endcase
    end

    // Three-row window: each returned row shifts in at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_win_new <= 1'b0;
            r_flags   <= '0;
        end else begin
            r_rd_vld  <= (r_state == S_READ);
            r_rd_ok   <= issue_ok;
            r_win_new <= r_rd_vld;
            if (in_fire) begin
                r_flags <= '0;
            end else if (r_rd_vld) begin
                r_flags <= '{top_ok: r_flags.mid_ok, mid_ok: r_flags.bot_ok, bot_ok: r_rd_ok};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_top <= r_mid;
            r_mid <= r_bot;
            r_bot <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_rows_in_use <= gwm_pkg::CFG_RESET;
            r_cols_in_use <= gwm_pkg::CFG_RESET;
            r_out_valid   <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == gwm_pkg::CFG_ROWS_IN_USE) begin
                    r_rows_in_use <= i_cfg_data;
                end else if (i_cfg_idx == gwm_pkg::CFG_COLS_IN_USE) begin
                    r_cols_in_use <= i_cfg_data;
                end
            end

            r_found <= in_fire ? 1'b0 : (r_found | scan_hit);

            if (done_fire) begin
                r_out_valid <= 1'b1;
                r_answer    <= n_answer;
                r_rej       <= n_rej;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(MAX_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_req <= i_req.req_type;
                        r_x   <= x_ext;
                        r_y   <= y_ext;
                        if (i_req.req_type == gwm_pkg::REQ_SCAN) begin
                            r_row   <= '0;
                            r_end   <= {1'b0, lim_rows};
                            r_state <= S_READ;
                        end else if (i_req.req_type <= gwm_pkg::REQ_QUERY_PILLAR) begin
                            r_row   <= y_ext - RW'(1);
                            r_end   <= y_ext + RW'(1);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    if (r_row == r_end) begin
                        r_state <= S_DRAIN0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
                S_DRAIN0: r_state <= S_DRAIN1;
                S_DRAIN1: r_state <= S_DONE;
                S_DONE: begin
                    if (done_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/gwm_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the grid wall map, bound to the top level.
// Sees only the top level's channel signals; no package dependency.
module gwm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_answer,
    input logic i_write_rejected
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // No response is pending right after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // One request at a time: the block is busy in the cycle after a transfer.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("request taken while previous one in flight");

    // A response never appears in the cycle after its request.
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(i_out_valid))
        else $error("response too early");

    // A rejected write carries no answer.
    a_reject_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_answer && i_write_rejected))
        else $error("rejected write with answer set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_answer)
                                        && $stable(i_write_rejected))
        else $error("stalled response changed");

endmodule

bind grid_wall_map_pillar_check_top gwm_checker u_gwm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_answer         (o_rsp.answer),
    .i_write_rejected (o_rsp.write_rejected)
);
